@@ rtl/core/owbm_pkg.sv @@
// owbm_pkg: shared types and constants for the one-wire bus master.
// Command kinds, phases, configuration layout and the transaction structs.
// No dependencies.
package owbm_pkg;

    localparam int CFG_W = 10;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_RESET = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CFG_RESET_LOW_TIME      = 3'd0,
        CFG_RESET_RELEASE_TIME  = 3'd1,
        CFG_PRESENCE_WAIT_LIMIT = 3'd2,
        CFG_PRESENCE_LOW_LIMIT  = 3'd3,
        CFG_SHORT_LOW_TIME      = 3'd4,
        CFG_LONG_SLOT_TIME      = 3'd5,
        CFG_READ_SAMPLE_DELAY   = 3'd6,
        CFG_READ_RECOVERY_TIME  = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_RST_LOW = 4'd1,
        PH_RST_REL = 4'd2,
        PH_PRES_W  = 4'd3,
        PH_PRES_L  = 4'd4,
        PH_WR_LOW  = 4'd5,
        PH_WR_REL  = 4'd6,
        PH_RD_LOW  = 4'd7,
        PH_RD_WAIT = 4'd8,
        PH_RD_REC  = 4'd9
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_time;
        logic [CFG_W-1:0] reset_release_time;
        logic [CFG_W-1:0] presence_wait_limit;
        logic [CFG_W-1:0] presence_low_limit;
        logic [CFG_W-1:0] short_low_time;
        logic [CFG_W-1:0] long_slot_time;
        logic [CFG_W-1:0] read_sample_delay;
        logic [CFG_W-1:0] read_recovery_time;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        reset_low_time:      10'd750,
        reset_release_time:  10'd15,
        presence_wait_limit: 10'd200,
        presence_low_limit:  10'd240,
        short_low_time:      10'd2,
        long_slot_time:      10'd60,
        read_sample_delay:   10'd12,
        read_recovery_time:  10'd50
    };

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence_ok;
        logic [7:0] read_data;
    } t_result;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

@@ rtl/core/one_wire_bus_master.sv @@
// one_wire_bus_master: top level; configuration registers, input queue,
// execution stage and result queue. Depends on owbm_pkg, owbm_front,
// owbm_exec, owbm_outq.
// Throughput: one transaction per cycle while the result queue has room;
// one pass of the phase machine per item; results queue as items are accepted.
// Synchronous active-low reset: queues empty, phase idle, registers at defaults.
module one_wire_bus_master #(
    parameter int TIMER_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_kind,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_line_level,
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_drive_low,
    output logic                        o_busy_res,
    output logic                        o_done_res,
    output logic                        o_presence_ok,
    output logic [7:0]                  o_read_data,
    input  logic                        i_cfg_wr_en,
    input  logic [2:0]                  i_cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0]  i_cfg_data
);

    owbm_pkg::t_cfg    r_cfg;
    owbm_pkg::t_item   w_item;
    owbm_pkg::t_result w_res, w_out;
    logic              w_item_valid, w_item_ack, w_res_room, w_res_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= owbm_pkg::CFG_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (owbm_pkg::t_cfg_idx'(i_cfg_index))
                owbm_pkg::CFG_RESET_LOW_TIME:      r_cfg.reset_low_time      <= i_cfg_data;
                owbm_pkg::CFG_RESET_RELEASE_TIME:  r_cfg.reset_release_time  <= i_cfg_data;
                owbm_pkg::CFG_PRESENCE_WAIT_LIMIT: r_cfg.presence_wait_limit <= i_cfg_data;
                owbm_pkg::CFG_PRESENCE_LOW_LIMIT:  r_cfg.presence_low_limit  <= i_cfg_data;
                owbm_pkg::CFG_SHORT_LOW_TIME:      r_cfg.short_low_time      <= i_cfg_data;
                owbm_pkg::CFG_LONG_SLOT_TIME:      r_cfg.long_slot_time      <= i_cfg_data;
                owbm_pkg::CFG_READ_SAMPLE_DELAY:   r_cfg.read_sample_delay   <= i_cfg_data;
                owbm_pkg::CFG_READ_RECOVERY_TIME:  r_cfg.read_recovery_time  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    owbm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_line_level (i_line_level),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_ack   (w_item_ack)
    );

    owbm_exec #(
        .TIMER_BITS (TIMER_BITS)
    ) u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_ack   (w_item_ack),
        .i_res_room   (w_res_room),
        .o_res_push   (w_res_push),
        .o_res        (w_res)
    );

    owbm_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_push (w_res_push),
        .i_res      (w_res),
        .o_res_room (w_res_room),
        .empty      (empty),
        .pop        (pop),
        .o_res      (w_out)
    );

    assign o_drive_low   = w_out.drive_low;
    assign o_busy_res    = w_out.busy_res;
    assign o_done_res    = w_out.done_res;
    assign o_presence_ok = w_out.presence_ok;
    assign o_read_data   = w_out.read_data;

endmodule

@@ rtl/core/owbm_front.sv @@
// owbm_front: input side of the bus master; classifies transactions and holds
// them in a two-entry queue for the execution stage.
// Depends on owbm_pkg.
module owbm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           i_kind,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_line_level,
    output logic                 o_item_valid,
    output owbm_pkg::t_item      o_item,
    input  logic                 i_item_ack
);

    owbm_pkg::t_item r_q0, r_q1;
    owbm_pkg::t_item w_in;
    logic [1:0]      r_cnt;
    logic            w_enq, w_deq;

    always_comb begin
        w_in.kind       = owbm_pkg::t_kind'(i_kind);
        w_in.data_byte  = i_data_byte;
        w_in.line_level = i_line_level;
    end

    assign full         = (r_cnt == 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q0;
    assign w_enq        = push && !full;
    assign w_deq        = o_item_valid && i_item_ack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_enq} - {1'b0, w_deq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_deq) begin
            if (r_cnt == 2'd2) begin
                r_q0 <= r_q1;
            end else if (w_enq) begin
                r_q0 <= w_in;
            end
            if (w_enq && r_cnt == 2'd2) begin
                r_q1 <= w_in;
            end
        end else if (w_enq) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= w_in;
            end else begin
                r_q1 <= w_in;
            end
        end
    end

endmodule

@@ rtl/core/owbm_exec.sv @@
// owbm_exec: execution stage of the bus master; phase machine, slot timer,
// bit counter and shift register; one transaction per cycle when the
// result queue has room. Depends on owbm_pkg.
module owbm_exec #(
    parameter int TIMER_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  owbm_pkg::t_cfg       i_cfg,
    input  logic                 i_item_valid,
    input  owbm_pkg::t_item      i_item,
    output logic                 o_item_ack,
    input  logic                 i_res_room,
    output logic                 o_res_push,
    output owbm_pkg::t_result    o_res
);

    localparam int CMP_W = (TIMER_BITS > owbm_pkg::CFG_W) ? TIMER_BITS : owbm_pkg::CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    owbm_pkg::t_phase         r_phase, n_phase;
    logic [TIMER_BITS-1:0]    r_timer, n_timer, w_tick_t;
    logic [3:0]               r_bits, n_bits, w_bits_dec;
    logic [7:0]               r_shift, n_shift, w_rd_out;
    logic                     r_flag, n_flag;
    logic                     w_fire, w_done, w_reached, w_pres_first, w_bit;
    logic [owbm_pkg::CFG_W-1:0] w_dur;

    assign w_fire       = i_item_valid && i_res_room;
    assign o_item_ack   = w_fire;
    assign o_res_push   = w_fire;
    assign w_bit        = r_shift[0];
    assign w_bits_dec   = r_bits - 4'd1;
    assign w_tick_t     = (r_timer == TMAX) ? r_timer : r_timer + 1'b1;
    assign w_reached    = (CMP_W'(w_tick_t) >= CMP_W'(w_dur)) || (w_tick_t == TMAX);
    assign w_pres_first = (i_cfg.presence_low_limit <= 10'd1);

    always_comb begin
        unique case (r_phase)
            owbm_pkg::PH_RST_LOW: w_dur = i_cfg.reset_low_time;
            owbm_pkg::PH_RST_REL: w_dur = i_cfg.reset_release_time;
            owbm_pkg::PH_PRES_W:  w_dur = i_cfg.presence_wait_limit;
            owbm_pkg::PH_PRES_L:  w_dur = i_cfg.presence_low_limit;
            owbm_pkg::PH_WR_LOW:  w_dur = w_bit ? i_cfg.short_low_time : i_cfg.long_slot_time;
            owbm_pkg::PH_WR_REL:  w_dur = w_bit ? i_cfg.long_slot_time : i_cfg.short_low_time;
            owbm_pkg::PH_RD_LOW:  w_dur = i_cfg.short_low_time;
            owbm_pkg::PH_RD_WAIT: w_dur = i_cfg.read_sample_delay;
            owbm_pkg::PH_RD_REC:  w_dur = i_cfg.read_recovery_time;
            default:              w_dur = '0;
        endcase
    end

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_timer  = r_timer;
        n_bits   = r_bits;
        n_shift  = r_shift;
        n_flag   = r_flag;
        w_done   = 1'b0;
        w_rd_out = '0;
        if (w_fire) begin
            if (r_phase == owbm_pkg::PH_IDLE) begin
                unique case (i_item.kind)
                    owbm_pkg::KIND_RESET: begin
                        n_flag  = 1'b0;
                        n_phase = owbm_pkg::PH_RST_LOW;
                        n_timer = '0;
                    end
                    owbm_pkg::KIND_WRITE: begin
                        n_shift = i_item.data_byte;
                        n_bits  = owbm_pkg::BITS_PER_BYTE;
                        n_phase = owbm_pkg::PH_WR_LOW;
                        n_timer = '0;
                    end
                    owbm_pkg::KIND_READ: begin
                        n_shift = '0;
                        n_bits  = owbm_pkg::BITS_PER_BYTE;
                        n_phase = owbm_pkg::PH_RD_LOW;
                        n_timer = '0;
                    end
                    default: ;
                endcase
            end else if (i_item.kind == owbm_pkg::KIND_TICK) begin
                n_timer = w_tick_t;
                unique case (r_phase)
                    owbm_pkg::PH_RST_LOW: begin
                        if (w_reached) begin
                            n_phase = owbm_pkg::PH_RST_REL;
                            n_timer = '0;
                        end
                    end
                    owbm_pkg::PH_RST_REL: begin
                        if (w_reached) begin
                            n_phase = owbm_pkg::PH_PRES_W;
                            n_timer = '0;
                        end
                    end
                    owbm_pkg::PH_PRES_W: begin
                        if (!i_item.line_level) begin
                            // first low sample counts toward the low limit
                            n_phase = owbm_pkg::PH_PRES_L;
                            n_timer = TIMER_BITS'(1);
                            if (w_pres_first) begin
                                n_flag = 1'b0;
                                w_done = 1'b1;
                            end
                        end else if (w_reached) begin
                            n_flag = 1'b0;
                            w_done = 1'b1;
                        end
                    end
                    owbm_pkg::PH_PRES_L: begin
                        if (i_item.line_level) begin
                            n_flag = 1'b1;
                            w_done = 1'b1;
                        end else if (w_reached) begin
                            n_flag = 1'b0;
                            w_done = 1'b1;
                        end
                    end
                    owbm_pkg::PH_WR_LOW: begin
                        if (w_reached) begin
                            n_phase = owbm_pkg::PH_WR_REL;
                            n_timer = '0;
                        end
                    end
                    owbm_pkg::PH_WR_REL: begin
                        if (w_reached) begin
                            n_shift = {1'b0, r_shift[7:1]};
                            n_bits  = w_bits_dec;
                            if (w_bits_dec == 4'd0) begin
                                w_done = 1'b1;
                            end else begin
                                n_phase = owbm_pkg::PH_WR_LOW;
                                n_timer = '0;
                            end
                        end
                    end
                    owbm_pkg::PH_RD_LOW: begin
                        if (w_reached) begin
                            n_phase = owbm_pkg::PH_RD_WAIT;
                            n_timer = '0;
                        end
                    end
                    owbm_pkg::PH_RD_WAIT: begin
                        if (w_reached) begin
                            n_shift = {i_item.line_level, r_shift[7:1]};
                            n_phase = owbm_pkg::PH_RD_REC;
                            n_timer = '0;
                        end
                    end
                    owbm_pkg::PH_RD_REC: begin
                        if (w_reached) begin
                            n_bits = w_bits_dec;
                            if (w_bits_dec == 4'd0) begin
                                w_rd_out = r_shift;
                                w_done   = 1'b1;
                            end else begin
                                n_phase = owbm_pkg::PH_RD_LOW;
                                n_timer = '0;
                            end
                        end
                    end
                    default: w_done = 1'b1;
                endcase
                if (w_done) begin
                    n_phase = owbm_pkg::PH_IDLE;
                    n_timer = '0;
                end
            end
        end
    end

    // outputs
    always_comb begin
        o_res.drive_low   = (n_phase == owbm_pkg::PH_RST_LOW) ||
                            (n_phase == owbm_pkg::PH_WR_LOW)  ||
                            (n_phase == owbm_pkg::PH_RD_LOW);
        o_res.busy_res    = (n_phase != owbm_pkg::PH_IDLE);
        o_res.done_res    = w_done;
        o_res.presence_ok = w_done && n_flag &&
                            ((r_phase == owbm_pkg::PH_PRES_W) ||
                             (r_phase == owbm_pkg::PH_PRES_L));
        o_res.read_data   = w_rd_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= owbm_pkg::PH_IDLE;
            r_timer <= '0;
            r_bits  <= '0;
            r_shift <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_flag  <= n_flag;
        end
    end

endmodule

@@ rtl/core/owbm_outq.sv @@
// owbm_outq: two-entry result queue between the execution stage and the
// consumer; decouples execution from pop stalls. Depends on owbm_pkg.
module owbm_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_push,
    input  owbm_pkg::t_result    i_res,
    output logic                 o_res_room,
    output logic                 empty,
    input  logic                 pop,
    output owbm_pkg::t_result    o_res
);

    owbm_pkg::t_result r_q0, r_q1;
    logic [1:0]        r_cnt;
    logic              w_enq, w_deq;

    assign o_res_room = (r_cnt != 2'd2);
    assign empty      = (r_cnt == 2'd0);
    assign o_res      = r_q0;
    assign w_enq      = i_res_push && o_res_room;
    assign w_deq      = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_enq} - {1'b0, w_deq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_deq) begin
            if (r_cnt == 2'd2) begin
                r_q0 <= r_q1;
            end else if (w_enq) begin
                r_q0 <= i_res;
            end
            if (w_enq && r_cnt == 2'd2) begin
                r_q1 <= i_res;
            end
        end else if (w_enq) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= i_res;
            end else begin
                r_q1 <= i_res;
            end
        end
    end

endmodule

@@ rtl/core/owbm_checker.sv @@
// owbm_checker: port-level assertions for one_wire_bus_master, attached by bind.
// Depends on one_wire_bus_master.
module owbm_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        empty,
    input  logic                        pop,
    input  logic                        o_drive_low,
    input  logic                        o_busy_res,
    input  logic                        o_done_res,
    input  logic                        o_presence_ok,
    input  logic [7:0]                  o_read_data
);

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_done_res) |-> !o_busy_res)
        else $error("done transaction still shows busy");

    a_drive_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_drive_low) |-> o_busy_res)
        else $error("line driven low while idle");

    a_results_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_done_res) |-> (!o_presence_ok && o_read_data == 8'd0))
        else $error("presence or read data without done");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_drive_low) && $stable(o_busy_res) &&
                              $stable(o_done_res) && $stable(o_read_data)))
        else $error("waiting result changed before pop");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (.*);

@@ tb/tb_one_wire_bus_master.sv @@
`timescale 1ns / 100ps
// tb_one_wire_bus_master: self-checking bench for the one-wire bus master.
// Streams reset, write and read commands with tick items, predicts each result in
// order and compares it field by field. Depends on owbm_pkg and one_wire_bus_master.
module tb_one_wire_bus_master;

    localparam int TIMER_BITS = 10;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
    localparam int MAX_SHOWN = 10;
    localparam int ITEM_TARGET = 1600;
    localparam int CYCLE_LIMIT = 100_000;
    localparam int HOLD_START = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int STEADY_FROM = 1000;
    localparam int STEADY_TO = 1400;
    localparam int IDLE_PCT = 16;

    class slot_timing_model;
        owbm_pkg::t_cfg        cfg;
        owbm_pkg::t_phase      phase;
        logic [TIMER_BITS-1:0] slot_timer;
        logic [3:0]            bits_left;
        logic [7:0]            shift_byte;
        logic                  presence_flag;
        owbm_pkg::t_result     results_due[$];
        int                    checked;
        int                    errors;

        function new();
            cfg = owbm_pkg::CFG_RESET;
            phase = owbm_pkg::PH_IDLE;
            slot_timer = '0;
            bits_left = '0;
            shift_byte = '0;
            presence_flag = 1'b0;
            checked = 0;
            errors = 0;
        endfunction

        function void enter(owbm_pkg::t_phase ph);
            phase = ph;
            slot_timer = '0;
        endfunction

        // saturating timer; true once the duration is reached
        function bit timer_hits(logic [owbm_pkg::CFG_W-1:0] dur);
            if (slot_timer != TIMER_MAX)
                slot_timer++;
            return slot_timer >= dur || slot_timer == TIMER_MAX;
        endfunction

        function void accept_item(owbm_pkg::t_item it);
            owbm_pkg::t_result r;
            bit                done;
            logic              lsb;
            r = '0;
            done = 1'b0;
            lsb = shift_byte[0];
            if (phase == owbm_pkg::PH_IDLE) begin
                case (it.kind)
                    owbm_pkg::KIND_RESET: begin
                        presence_flag = 1'b0;
                        enter(owbm_pkg::PH_RST_LOW);
                    end
                    owbm_pkg::KIND_WRITE: begin
                        shift_byte = it.data_byte;
                        bits_left = owbm_pkg::BITS_PER_BYTE;
                        enter(owbm_pkg::PH_WR_LOW);
                    end
                    owbm_pkg::KIND_READ: begin
                        shift_byte = '0;
                        bits_left = owbm_pkg::BITS_PER_BYTE;
                        enter(owbm_pkg::PH_RD_LOW);
                    end
                    default: ;
                endcase
            end else if (it.kind == owbm_pkg::KIND_TICK) begin
                case (phase)
                    owbm_pkg::PH_RST_LOW: begin
                        if (timer_hits(cfg.reset_low_time))
                            enter(owbm_pkg::PH_RST_REL);
                    end
                    owbm_pkg::PH_RST_REL: begin
                        if (timer_hits(cfg.reset_release_time))
                            enter(owbm_pkg::PH_PRES_W);
                    end
                    owbm_pkg::PH_PRES_W: begin
                        if (!it.line_level) begin
                            enter(owbm_pkg::PH_PRES_L);
                            if (timer_hits(cfg.presence_low_limit)) begin
                                presence_flag = 1'b0;
                                done = 1'b1;
                            end
                        end else if (timer_hits(cfg.presence_wait_limit)) begin
                            presence_flag = 1'b0;
                            done = 1'b1;
                        end
                    end
                    owbm_pkg::PH_PRES_L: begin
                        if (it.line_level) begin
                            presence_flag = 1'b1;
                            done = 1'b1;
                        end else if (timer_hits(cfg.presence_low_limit)) begin
                            presence_flag = 1'b0;
                            done = 1'b1;
                        end
                    end
                    owbm_pkg::PH_WR_LOW: begin
                        if (timer_hits(lsb ? cfg.short_low_time : cfg.long_slot_time))
                            enter(owbm_pkg::PH_WR_REL);
                    end
                    owbm_pkg::PH_WR_REL: begin
                        if (timer_hits(lsb ? cfg.long_slot_time : cfg.short_low_time)) begin
                            shift_byte = shift_byte >> 1;
                            bits_left--;
                            if (bits_left == 0)
                                done = 1'b1;
                            else
                                enter(owbm_pkg::PH_WR_LOW);
                        end
                    end
                    owbm_pkg::PH_RD_LOW: begin
                        if (timer_hits(cfg.short_low_time))
                            enter(owbm_pkg::PH_RD_WAIT);
                    end
                    owbm_pkg::PH_RD_WAIT: begin
                        if (timer_hits(cfg.read_sample_delay)) begin
                            shift_byte = {it.line_level, shift_byte[7:1]};
                            enter(owbm_pkg::PH_RD_REC);
                        end
                    end
                    owbm_pkg::PH_RD_REC: begin
                        if (timer_hits(cfg.read_recovery_time)) begin
                            bits_left--;
                            if (bits_left == 0) begin
                                r.read_data = shift_byte;
                                done = 1'b1;
                            end else begin
                                enter(owbm_pkg::PH_RD_LOW);
                            end
                        end
                    end
                    default: done = 1'b1;
                endcase
                if (done) begin
                    if (phase == owbm_pkg::PH_PRES_W || phase == owbm_pkg::PH_PRES_L)
                        r.presence_ok = presence_flag;
                    enter(owbm_pkg::PH_IDLE);
                end
            end
            r.drive_low = phase inside {owbm_pkg::PH_RST_LOW, owbm_pkg::PH_WR_LOW,
                                        owbm_pkg::PH_RD_LOW};
            r.busy_res = phase != owbm_pkg::PH_IDLE;
            r.done_res = done;
            results_due.push_back(r);
        endfunction

        function void mismatch(string field, logic [7:0] want, logic [7:0] got);
            errors++;
            if (errors <= MAX_SHOWN)
                $display("result %0d: %s expected %0h, got %0h", checked, field, want, got);
        endfunction

        function void check_result(owbm_pkg::t_result got);
            owbm_pkg::t_result want;
            if (results_due.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("result %0d: nothing outstanding, got %p", checked, got);
                return;
            end
            want = results_due.pop_front();
            if (got.drive_low !== want.drive_low)
                mismatch("drive_low", 8'(want.drive_low), 8'(got.drive_low));
            if (got.busy_res !== want.busy_res)
                mismatch("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            if (got.done_res !== want.done_res)
                mismatch("done_res", 8'(want.done_res), 8'(got.done_res));
            if (got.presence_ok !== want.presence_ok)
                mismatch("presence_ok", 8'(want.presence_ok), 8'(got.presence_ok));
            if (got.read_data !== want.read_data)
                mismatch("read_data", want.read_data, got.read_data);
            checked++;
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        push = 1'b0;
    logic                        full;
    logic [1:0]                  i_kind = owbm_pkg::KIND_TICK;
    logic [7:0]                  i_data_byte = '0;
    logic                        i_line_level = 1'b1;
    logic                        empty;
    logic                        pop = 1'b0;
    logic                        o_drive_low;
    logic                        o_busy_res;
    logic                        o_done_res;
    logic                        o_presence_ok;
    logic [7:0]                  o_read_data;
    logic                        i_cfg_wr_en = 1'b0;
    logic [2:0]                  i_cfg_index = owbm_pkg::CFG_RESET_LOW_TIME;
    logic [owbm_pkg::CFG_W-1:0]  i_cfg_data = '0;

    slot_timing_model model = new();
    int  cycle = 0;
    int  hold_left = 0;
    int  sent_items = 0;
    int  go_low_odds = 0;
    int  go_high_odds = 0;

    one_wire_bus_master #(
        .TIMER_BITS(TIMER_BITS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_kind(i_kind),
        .i_data_byte(i_data_byte),
        .i_line_level(i_line_level),
        .empty(empty),
        .pop(pop),
        .o_drive_low(o_drive_low),
        .o_busy_res(o_busy_res),
        .o_done_res(o_done_res),
        .o_presence_ok(o_presence_ok),
        .o_read_data(o_read_data),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic bit in_steady();
        return cycle >= STEADY_FROM && cycle < STEADY_TO;
    endfunction

    // result side: checks each transaction, idles at random, one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty)
                model.check_result(owbm_pkg::t_result'({o_drive_low, o_busy_res,
                                                        o_done_res, o_presence_ok,
                                                        o_read_data}));
            if (cycle == HOLD_START)
                hold_left = HOLD_CYCLES;
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= in_steady() || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    task automatic push_item(owbm_pkg::t_item it);
        while (!in_steady() && $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_kind <= it.kind;
        i_data_byte <= it.data_byte;
        i_line_level <= it.line_level;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        sent_items++;
        model.accept_item(it);
    endtask

    task automatic cfg_reg(owbm_pkg::t_cfg_idx idx, logic [owbm_pkg::CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_cfg(owbm_pkg::t_cfg c);
        cfg_reg(owbm_pkg::CFG_RESET_LOW_TIME, c.reset_low_time);
        cfg_reg(owbm_pkg::CFG_RESET_RELEASE_TIME, c.reset_release_time);
        cfg_reg(owbm_pkg::CFG_PRESENCE_WAIT_LIMIT, c.presence_wait_limit);
        cfg_reg(owbm_pkg::CFG_PRESENCE_LOW_LIMIT, c.presence_low_limit);
        cfg_reg(owbm_pkg::CFG_SHORT_LOW_TIME, c.short_low_time);
        cfg_reg(owbm_pkg::CFG_LONG_SLOT_TIME, c.long_slot_time);
        cfg_reg(owbm_pkg::CFG_READ_SAMPLE_DELAY, c.read_sample_delay);
        cfg_reg(owbm_pkg::CFG_READ_RECOVERY_TIME, c.read_recovery_time);
        i_cfg_wr_en <= 1'b0;
        model.cfg = c;
    endtask

    task automatic wait_drained();
        while (model.results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // device side of the line: presence pulse follows the odds set per reset
    function automatic logic pick_line();
        case (model.phase)
            owbm_pkg::PH_PRES_W:
                return !(go_low_odds != 0 && $urandom_range(1, go_low_odds) == 1);
            owbm_pkg::PH_PRES_L:
                return go_high_odds != 0 && $urandom_range(1, go_high_odds) == 1;
            default:
                return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 4;
            4:       return 16;
            default: return 64;
        endcase
    endfunction

    function automatic logic [owbm_pkg::CFG_W-1:0] rand_dur();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 10'd1;
            2:       return 10'd2;
            default: return 10'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic owbm_pkg::t_cfg rand_cfg();
        owbm_pkg::t_cfg c;
        c.reset_low_time = rand_dur();
        c.reset_release_time = rand_dur();
        c.presence_wait_limit = rand_dur();
        c.presence_low_limit = rand_dur();
        c.short_low_time = rand_dur();
        c.long_slot_time = rand_dur();
        c.read_sample_delay = rand_dur();
        c.read_recovery_time = rand_dur();
        return c;
    endfunction

    // one command, then ticks until the bus master is idle again; a few
    // commands land while busy and must be ignored
    task automatic run_op(owbm_pkg::t_kind k, logic [7:0] d, int low_odds, int high_odds);
        owbm_pkg::t_item it;
        go_low_odds = low_odds;
        go_high_odds = high_odds;
        it.kind = k;
        it.data_byte = d;
        it.line_level = 1'($urandom_range(0, 1));
        push_item(it);
        while (model.phase != owbm_pkg::PH_IDLE) begin
            if ($urandom_range(0, 99) < 3)
                it.kind = owbm_pkg::t_kind'($urandom_range(owbm_pkg::KIND_RESET,
                                                           owbm_pkg::KIND_READ));
            else
                it.kind = owbm_pkg::KIND_TICK;
            it.data_byte = 8'($urandom);
            it.line_level = pick_line();
            push_item(it);
        end
    endtask

    task automatic run_ops(int n_ops);
        owbm_pkg::t_item it;
        repeat (n_ops) begin
            while ($urandom_range(0, 9) == 0) begin
                it.kind = owbm_pkg::KIND_TICK;
                it.data_byte = 8'($urandom);
                it.line_level = 1'($urandom_range(0, 1));
                push_item(it);
            end
            run_op(owbm_pkg::t_kind'($urandom_range(owbm_pkg::KIND_RESET,
                                                    owbm_pkg::KIND_READ)),
                   8'($urandom), pick_odds(), pick_odds());
        end
        push <= 1'b0;
    endtask

    initial begin
        owbm_pkg::t_cfg  c;
        owbm_pkg::t_item it;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // power-up register values, receiver hold-off falls in here
        run_op(owbm_pkg::KIND_WRITE, 8'($urandom), 0, 0);
        push <= 1'b0;
        wait_drained();

        // shortest timings, zero durations act as one
        c = '0;
        c.presence_wait_limit = 10'd3;
        c.presence_low_limit = 10'd2;
        load_cfg(c);
        it.kind = owbm_pkg::KIND_TICK;
        it.data_byte = 8'hFF;
        it.line_level = 1'b0;
        push_item(it);
        it.data_byte = 8'h00;
        it.line_level = 1'b1;
        push_item(it);
        run_op(owbm_pkg::KIND_RESET, 8'h00, 1, 1);
        run_op(owbm_pkg::KIND_RESET, 8'hFF, 0, 0);
        run_op(owbm_pkg::KIND_RESET, 8'h00, 1, 0);
        run_op(owbm_pkg::KIND_WRITE, 8'h00, 0, 0);
        run_op(owbm_pkg::KIND_WRITE, 8'hFF, 0, 0);
        run_op(owbm_pkg::KIND_READ, 8'h5A, 0, 0);
        push <= 1'b0;
        wait_drained();

        c.reset_low_time = 10'd1;
        c.reset_release_time = 10'd1;
        c.presence_wait_limit = 10'd1;
        c.presence_low_limit = 10'd1;
        c.short_low_time = 10'd1;
        c.long_slot_time = 10'd1;
        c.read_sample_delay = 10'd1;
        c.read_recovery_time = 10'd1;
        load_cfg(c);
        run_ops(4);
        wait_drained();

        while (sent_items < ITEM_TARGET) begin
            load_cfg(rand_cfg());
            run_ops(2);
            wait_drained();
        end

        if (model.errors == 0 && model.results_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
